FILE: hdl/tun_pkg.sv
// Shared widths, constants and the payload type of the triangle unit normal pipeline.
package tun_pkg;

    localparam int VW = 16;              // vertex coordinate, Q12.4
    localparam int EW = VW + 1;          // edge component
    localparam int PW = 2 * EW;          // edge product
    localparam int NW = PW + 1;          // cross product component, signed
    localparam int MW = NW - 1;          // cross product magnitude
    localparam int HW = (MW + 1) / 2;    // half of a magnitude for the squarer
    localparam int SQW = 2 * MW;         // one square
    localparam int SW = SQW + 2;         // sum of three squares
    localparam int RW = SW / 2;          // square root
    localparam int QW = 15;              // quotient bits
    localparam int FB = 14;              // fraction bits of the unit result
    localparam int DW = RW + QW;         // divider remainder
    localparam int UW = 16;              // unit component

    localparam logic [QW-1:0] UNIT_ONE = QW'(16384);

    typedef struct packed {
        logic [2:0]         neg;
        logic [2:0][MW-1:0] mag;
    } t_norm;

endpackage

FILE: hdl/tun_cross.sv
// Edge vectors, cross product and sign/magnitude split, three register stages.
module tun_cross import tun_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ce,
    input  logic               i_vld,
    input  logic [8:0][VW-1:0] i_vtx,
    output logic               o_vld,
    output t_norm              o_norm
);

    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [PW-1:0] r_p  [6];
    logic signed [NW-1:0] c_n  [3];
    logic [2:0]           r_vld;
    t_norm                r_norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= EW'($signed(i_vtx[3+i])) - EW'($signed(i_vtx[i]));
                r_e2[i] <= EW'($signed(i_vtx[6+i])) - EW'($signed(i_vtx[i]));
            end
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
            for (int i = 0; i < 3; i++) begin
                r_norm.neg[i] <= c_n[i][NW-1];
                r_norm.mag[i] <= c_n[i][NW-1] ? MW'(-c_n[i]) : MW'(c_n[i]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_n[i] = NW'(r_p[2*i]) - NW'(r_p[2*i+1]);
        end
    end

    assign o_vld  = r_vld[2];
    assign o_norm = r_norm;

endmodule

FILE: hdl/tun_sqsum.sv
// Sum of squares of the cross product magnitudes from partial products of 17-bit halves.
module tun_sqsum import tun_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_vld,
    input  t_norm         i_norm,
    output logic          o_vld,
    output t_norm         o_norm,
    output logic [SW-1:0] o_sum
);

    logic [2*HW-1:0] r_hh [3];
    logic [2*HW-1:0] r_hl [3];
    logic [2*HW-1:0] r_ll [3];
    logic [SQW-1:0]  r_sq [3];
    logic [SW-1:0]   r_sum;
    t_norm           r_norm [3];
    logic [2:0]      r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ce) begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int i = 0; i < 3; i++) begin
                r_hh[i] <= i_norm.mag[i][MW-1:HW] * i_norm.mag[i][MW-1:HW];
                r_hl[i] <= i_norm.mag[i][MW-1:HW] * i_norm.mag[i][HW-1:0];
                r_ll[i] <= i_norm.mag[i][HW-1:0] * i_norm.mag[i][HW-1:0];
                r_sq[i] <= (SQW'(r_hh[i]) << (2 * HW)) + (SQW'(r_hl[i]) << (HW + 1))
                         + SQW'(r_ll[i]);
            end
            r_sum     <= SW'(r_sq[0]) + SW'(r_sq[1]) + SW'(r_sq[2]);
            r_norm[0] <= i_norm;
            r_norm[1] <= r_norm[0];
            r_norm[2] <= r_norm[1];
        end
    end

    assign o_vld  = r_vld[2];
    assign o_norm = r_norm[2];
    assign o_sum  = r_sum;

endmodule

FILE: hdl/tun_isqrt.sv
// Floor square root, one result bit per register stage.
module tun_isqrt import tun_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ce,
    input  logic          i_vld,
    input  t_norm         i_norm,
    input  logic [SW-1:0] i_sum,
    output logic          o_vld,
    output t_norm         o_norm,
    output logic [RW-1:0] o_root
);

    logic [SW-1:0] r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    t_norm         r_norm [RW];
    logic          r_vld  [RW];

    for (genvar j = 0; j < RW; j++) begin : g_stage
        localparam int B = RW - 1 - j;
        logic [SW-1:0] w_rem;
        logic [RW-1:0] w_root;
        t_norm         w_norm;
        logic          w_vld;
        logic [SW:0]   w_trial;

        if (j == 0) begin : g_first
            assign w_rem  = i_sum;
            assign w_root = '0;
            assign w_norm = i_norm;
            assign w_vld  = i_vld;
        end else begin : g_next
            assign w_rem  = r_rem[j-1];
            assign w_root = r_root[j-1];
            assign w_norm = r_norm[j-1];
            assign w_vld  = r_vld[j-1];
        end

        // (root + 2^B)^2 - root^2
        assign w_trial = ((SW+1)'(w_root) << (B + 1)) | ((SW+1)'(1) << (2 * B));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_ce) begin
                r_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_norm[j] <= w_norm;
                if (w_trial <= {1'b0, w_rem}) begin
                    r_rem[j]  <= w_rem - w_trial[SW-1:0];
                    r_root[j] <= w_root | (RW'(1) << B);
                end else begin
                    r_rem[j]  <= w_rem;
                    r_root[j] <= w_root;
                end
            end
        end
    end

    assign o_vld  = r_vld[RW-1];
    assign o_norm = r_norm[RW-1];
    assign o_root = r_root[RW-1];

endmodule

FILE: hdl/tun_div.sv
// Three-lane restoring divider, one quotient bit per stage, then saturate and sign.
module tun_div import tun_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_ce,
    input  logic               i_vld,
    input  t_norm              i_norm,
    input  logic [RW-1:0]      i_root,
    output logic               o_vld,
    output logic [2:0][UW-1:0] o_unit,
    output logic               o_degen
);

    logic [2:0][DW-1:0] r_rem  [QW];
    logic [2:0][QW-1:0] r_quo  [QW];
    logic [RW-1:0]      r_len  [QW];
    logic [2:0]         r_neg  [QW];
    logic               r_vld  [QW];
    logic [2:0][UW-1:0] r_unit;
    logic               r_degen;
    logic               r_ovld;
    logic [QW-1:0]      c_sat  [3];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int B = QW - 1 - j;
        logic [2:0][DW-1:0] w_rem;
        logic [2:0][QW-1:0] w_quo;
        logic [RW-1:0]      w_len;
        logic [2:0]         w_neg;
        logic               w_vld;
        logic [DW-1:0]      w_den;

        if (j == 0) begin : g_first
            for (genvar k = 0; k < 3; k++) begin : g_lane
                assign w_rem[k] = DW'(i_norm.mag[k]) << FB;
            end
            assign w_quo = '0;
            assign w_len = i_root;
            assign w_neg = i_norm.neg;
            assign w_vld = i_vld;
        end else begin : g_next
            assign w_rem = r_rem[j-1];
            assign w_quo = r_quo[j-1];
            assign w_len = r_len[j-1];
            assign w_neg = r_neg[j-1];
            assign w_vld = r_vld[j-1];
        end

        assign w_den = DW'(w_len) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_ce) begin
                r_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_len[j] <= w_len;
                r_neg[j] <= w_neg;
                for (int k = 0; k < 3; k++) begin
                    if (w_rem[k] >= w_den) begin
                        r_rem[j][k] <= w_rem[k] - w_den;
                        r_quo[j][k] <= w_quo[k] | (QW'(1) << B);
                    end else begin
                        r_rem[j][k] <= w_rem[k];
                        r_quo[j][k] <= w_quo[k];
                    end
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_sat[k] = (r_quo[QW-1][k] > UNIT_ONE) ? UNIT_ONE : r_quo[QW-1][k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (i_ce) begin
            r_ovld <= r_vld[QW-1];
        end
    end

    // zero length: drop the quotients and flag the triangle
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_degen <= (r_len[QW-1] == '0);
            for (int k = 0; k < 3; k++) begin
                if (r_len[QW-1] == '0) begin
                    r_unit[k] <= '0;
                end else if (r_neg[QW-1][k]) begin
                    r_unit[k] <= UW'(-UW'(c_sat[k]));
                end else begin
                    r_unit[k] <= UW'(c_sat[k]);
                end
            end
        end
    end

    assign o_vld   = r_ovld;
    assign o_unit  = r_unit;
    assign o_degen = r_degen;

endmodule

FILE: hdl/triangle_unit_normal_unit.sv
// Top level of the triangle unit normal: pipeline stages and output register slice.
//
// Slave channel i_s_*: one triangle per transaction, nine signed Q12.4
// coordinates in i_s_tdata. Master channel o_m_*: one unit normal per
// triangle, three signed Q1.14 components in o_m_tdata and the degenerate
// flag in o_m_tuser. Results leave in the order the triangles arrived.
// Throughput: one triangle per clock while o_s_tready is high. Stages from
// the accepting edge to o_m_tvalid: 3 of edges and cross product, 3 of
// squaring and summing, 35 of square root (one root bit each), 16 of division
// (one quotient bit each, then saturate and sign), and the output register.
// A zero-length cross product gives a zero vector with o_m_tuser set.
// Reset (i_rst_n low at a clock edge) empties every stage and the output;
// triangles in flight are dropped. When the receiver holds i_m_tready low
// the output register keeps its transaction, one more result is parked in
// a skid register, and then o_s_tready falls and the whole pipeline holds
// its place until the output drains; nothing is lost or repeated.
module triangle_unit_normal_unit import tun_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    output logic           o_s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each)
    input  logic [143:0]   i_s_tdata,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    // unit_x, unit_y, unit_z (16 bits each)
    output logic [47:0]    o_m_tdata,
    // degenerate
    output logic [0:0]     o_m_tuser
);

    logic               ce;
    logic               cr_vld;
    t_norm              cr_norm;
    logic               sq_vld;
    t_norm              sq_norm;
    logic [SW-1:0]      sq_sum;
    logic               rt_vld;
    t_norm              rt_norm;
    logic [RW-1:0]      rt_root;
    logic               dv_vld;
    logic [2:0][UW-1:0] dv_unit;
    logic               dv_degen;

    logic               r_out_vld;
    logic [47:0]        r_out_data;
    logic               r_out_degen;
    logic               r_skid_vld;
    logic [47:0]        r_skid_data;
    logic               r_skid_degen;
    logic               out_free;

    assign ce         = !r_skid_vld;
    assign out_free   = !r_out_vld || i_m_tready;
    assign o_s_tready = ce;

    tun_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (i_s_tvalid),
        .i_vtx   (i_s_tdata),
        .o_vld   (cr_vld),
        .o_norm  (cr_norm)
    );

    tun_sqsum u_sqsum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (cr_vld),
        .i_norm  (cr_norm),
        .o_vld   (sq_vld),
        .o_norm  (sq_norm),
        .o_sum   (sq_sum)
    );

    tun_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (sq_vld),
        .i_norm  (sq_norm),
        .i_sum   (sq_sum),
        .o_vld   (rt_vld),
        .o_norm  (rt_norm),
        .o_root  (rt_root)
    );

    tun_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (ce),
        .i_vld   (rt_vld),
        .i_norm  (rt_norm),
        .i_root  (rt_root),
        .o_vld   (dv_vld),
        .o_unit  (dv_unit),
        .o_degen (dv_degen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (out_free) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (out_free) begin
            r_out_vld <= dv_vld;
        end else if (dv_vld) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (out_free) begin
                r_out_data  <= r_skid_data;
                r_out_degen <= r_skid_degen;
            end
        end else if (out_free) begin
            r_out_data  <= dv_unit;
            r_out_degen <= dv_degen;
        end else begin
            r_skid_data  <= dv_unit;
            r_skid_degen <= dv_degen;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_degen;

endmodule

FILE: tb/tb.sv
// Testbench of the triangle unit normal: random and directed triangles, checked against a predictor.
module tb;

    typedef struct packed {
        logic signed [15:0] ux;
        logic signed [15:0] uy;
        logic signed [15:0] uz;
        logic               degen;
    } t_normal;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [143:0] i_s_tdata = '0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [47:0]  o_m_tdata;
    logic [0:0]   o_m_tuser;

    t_normal normal_q[$];
    int      errors = 0;
    int      hold_cycles = 0;
    bit      stall_enable = 1'b1;

    always #5 i_clk = ~i_clk;

    triangle_unit_normal_unit i_dut (.*);

    function automatic logic [71:0] floor_sqrt(input logic [71:0] s);
        logic [35:0] r;
        logic [35:0] t;
        r = '0;
        for (int b = 35; b >= 0; b--) begin
            t = r | (36'd1 << b);
            if ({36'd0, t} * {36'd0, t} <= s) r = t;
        end
        return {36'd0, r};
    endfunction

    function automatic logic signed [15:0] scale_component(input logic signed [63:0] n,
                                                           input logic [71:0] len);
        logic [71:0] m;
        logic [71:0] q;
        m = (n < 0) ? 72'(-n) : 72'(n);
        q = (m * 72'd16384) / len;
        if (q > 72'd16384) q = 72'd16384;
        return (n < 0) ? -16'(q) : 16'(q);
    endfunction

    function automatic t_normal predict_normal(input logic [143:0] tri_data);
        logic signed [63:0] v[9];
        logic signed [63:0] e1x, e1y, e1z, e2x, e2y, e2z, nx, ny, nz;
        logic [71:0] sum, len;
        t_normal r;
        for (int i = 0; i < 9; i++) v[i] = 64'(signed'(tri_data[16*i +: 16]));
        e1x = v[3] - v[0]; e1y = v[4] - v[1]; e1z = v[5] - v[2];
        e2x = v[6] - v[0]; e2y = v[7] - v[1]; e2z = v[8] - v[2];
        nx = e1y * e2z - e1z * e2y;
        ny = e1z * e2x - e1x * e2z;
        nz = e1x * e2y - e1y * e2x;
        // squares reach past 64 bits, widen before multiplying
        sum = 72'(nx) * 72'(nx) + 72'(ny) * 72'(ny) + 72'(nz) * 72'(nz);
        len = floor_sqrt(sum);
        if (len == 0) begin
            r = '{16'sd0, 16'sd0, 16'sd0, 1'b1};
        end else begin
            r = '{scale_component(nx, len), scale_component(ny, len),
                  scale_component(nz, len), 1'b0};
        end
        return r;
    endfunction

    // Sender: one transaction per call, with a gap given by the caller first.
    task automatic send_triangle(input logic [143:0] tri_data, input int gap);
        repeat (gap) begin
            @(posedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(posedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= tri_data;
        normal_q.push_back(predict_normal(tri_data));
        do @(posedge i_clk); while (!o_s_tready);
        i_s_tvalid <= 1'b0;
    endtask

    task automatic send_burst(input logic [143:0] tri_data);
        // keep tvalid high across back-to-back items
        int gap;
        gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end else if (!i_s_tvalid) begin
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= tri_data;
        normal_q.push_back(predict_normal(tri_data));
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    function automatic logic [143:0] pack_tri(input logic [15:0] c[9]);
        logic [143:0] d;
        for (int i = 0; i < 9; i++) d[16*i +: 16] = c[i];
        return d;
    endfunction

    function automatic logic [143:0] random_tri(input int mode);
        logic [15:0] c[9];
        for (int i = 0; i < 9; i++) begin
            case (mode)
                0: c[i] = 16'($urandom);
                1: c[i] = 16'($urandom_range(0, 64)) - 16'd32;
                default: c[i] = 16'($urandom_range(0, 4096)) - 16'd2048;
            endcase
        end
        // collinear or repeated vertex now and then
        if (mode == 1 && $urandom_range(0, 3) == 0) begin
            for (int i = 0; i < 3; i++) c[6 + i] = c[3 + i];
        end
        return pack_tri(c);
    endfunction

    task automatic drain_wait();
        while (normal_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        logic [15:0] c[9];
        logic [15:0] ext[4] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
        // all vertices equal: degenerate
        foreach (c[i]) c[i] = 16'h0000;
        send_triangle(pack_tri(c), 0);
        foreach (c[i]) c[i] = 16'h8000;
        send_triangle(pack_tri(c), 0);
        // axis-aligned unit triangles with normals along +z, -z, +y and +x
        c = '{0, 0, 0, 16'h0010, 0, 0, 0, 16'h0010, 0};
        send_triangle(pack_tri(c), 1);
        c = '{0, 0, 0, 0, 16'h0010, 0, 16'h0010, 0, 0};
        send_triangle(pack_tri(c), 0);
        c = '{0, 0, 0, 0, 0, 16'h0010, 16'h0010, 0, 0};
        send_triangle(pack_tri(c), 0);
        c = '{0, 0, 0, 0, 16'h0010, 0, 0, 0, 16'h0010};
        send_triangle(pack_tri(c), 0);
        // collinear: degenerate
        c = '{0, 0, 0, 16'h0001, 16'h0001, 16'h0001, 16'h0002, 16'h0002, 16'h0002};
        send_triangle(pack_tri(c), 0);
        // largest edges, opposite corners
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
              16'h8000, 16'h7fff, 16'h8000};
        send_triangle(pack_tri(c), 0);
        c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
              16'h8000, 16'h8000, 16'h7fff};
        send_triangle(pack_tri(c), 0);
        // near-diagonal normals where the floor length can saturate
        c = '{0, 0, 0, 16'h0001, 16'hffff, 0, 16'h0001, 0, 16'hffff};
        send_triangle(pack_tri(c), 0);
        c = '{0, 0, 0, 16'h0001, 0, 0, 0, 16'h0001, 16'h0001};
        send_triangle(pack_tri(c), 0);
        for (int k = 0; k < 12; k++) begin
            foreach (c[i]) c[i] = ext[$urandom_range(0, 3)];
            send_triangle(pack_tri(c), 0);
        end
        drain_wait();
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++) send_burst(random_tri($urandom_range(0, 2)));
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_backpressure();
        // hold the receiver off while the sender keeps offering
        hold_cycles = 200;
        for (int k = 0; k < 120; k++) send_burst(random_tri(0));
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        drain_wait();
    endtask

    // Receiver stall pattern, with a long hold when requested.
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_tready <= 1'b0;
        end else if (!stall_enable) begin
            i_m_tready <= 1'b1;
        end else begin
            i_m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Check each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_normal got;
        t_normal want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{o_m_tdata[15:0], o_m_tdata[31:16], o_m_tdata[47:32], o_m_tuser[0]};
            if (normal_q.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
            end else begin
                want = normal_q.pop_front();
                if (got !== want) begin
                    $display("%0t: expected %p actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(400);
        // sender pauses until every result is back
        drain_wait();
        test_backpressure();
        stall_enable = 1'b0;
        test_random(250);
        stall_enable = 1'b1;
        test_random(260);
        drain_wait();
        repeat (80) @(posedge i_clk);
        if (errors == 0 && normal_q.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

endmodule

FILE: sim.f
hdl/tun_pkg.sv
hdl/tun_cross.sv
hdl/tun_sqsum.sv
hdl/tun_isqrt.sv
hdl/tun_div.sv
hdl/triangle_unit_normal_unit.sv
tb/tb.sv
